// ----- sv/ccs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants of the crystal cluster spike filter
// Field widths, configuration register indexes, reset values and the
// structures passed between the front, the job queue and the divider.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int ENERGY_BITS    = 24;
    localparam int HIT_INDEX_BITS = 10;

    localparam int ETA_BITS       = 8;
    localparam int PHI_BITS       = 9;
    localparam int MAX_HITS_BITS  = 10;
    localparam int THRESH_BITS    = 16;
    localparam int FLOOR_BITS     = 24;
    localparam int LIMIT_BITS     = 7;
    localparam int RATIO_BITS     = 19;
    localparam int FRAC_BITS      = 15;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;

    // The neighbor maximum holds either a hit energy or the floor value.
    localparam int NMAX_BITS = (ENERGY_BITS > FLOOR_BITS) ? ENERGY_BITS : FLOOR_BITS;
    localparam int NUM_BITS  = NMAX_BITS + 1;
    localparam int SUM_BITS  = ENERGY_BITS + HIT_INDEX_BITS;
    localparam int POS_CMP_BITS =
        (HIT_INDEX_BITS > MAX_HITS_BITS) ? HIT_INDEX_BITS : MAX_HITS_BITS;

    // Divider sizes: magnitude of the numerator scaled to Q15 over a
    // positive window sum.
    localparam int DVD_BITS = NUM_BITS + FRAC_BITS;
    localparam int DVS_BITS = SUM_BITS - 1;
    localparam int CNT_BITS = $clog2(DVD_BITS + 1);

    localparam int PHI_WRAP = 359;

    localparam logic [MAX_HITS_BITS-1:0]      MAX_HITS_RST = MAX_HITS_BITS'(100);
    localparam logic [THRESH_BITS-1:0]        THRESH_RST   = THRESH_BITS'(31130);
    localparam logic signed [FLOOR_BITS-1:0]  FLOOR_RST    = -FLOOR_BITS'(10000);
    localparam logic [LIMIT_BITS-1:0]         LIMIT_RST    = LIMIT_BITS'(85);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MAX_HITS    = 2'd0,
        CFG_SPIKE_THR   = 2'd1,
        CFG_NBR_FLOOR   = 2'd2,
        CFG_ETA_LIMIT   = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [MAX_HITS_BITS-1:0]     max_hits;
        logic [THRESH_BITS-1:0]       spike_threshold;
        logic signed [FLOOR_BITS-1:0] neighbor_floor;
        logic [LIMIT_BITS-1:0]        barrel_eta_limit;
    } t_cfg;

    // One finished cluster waiting for its division.
    typedef struct packed {
        logic signed [NUM_BITS-1:0] num;
        logic signed [SUM_BITS-1:0] sum;
    } t_job;

    typedef struct packed {
        logic signed [RATIO_BITS-1:0] ratio;
        logic                         is_spike;
        logic                         no_energy;
    } t_result;

endpackage

// ----- sv/crystal_cluster_e2e9_spike.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crystal_cluster_e2e9_spike: E2/E9 spike filter for calorimeter clusters
// Accumulates the 3x3 window around the seed crystal of each cluster and
// reports (neighbor maximum + seed energy) / window sum in signed Q15 with a
// spike flag and an empty-window flag.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Beat contents
//  -------   ---------------------   ------------------------------------------
//  hits      push / full             i_eta_index, i_phi_index, i_energy,
//                                    i_last_hit
//  results   pop / empty             o_ratio, o_is_spike, o_no_energy
//  config    i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A hit beat is taken and folded into the running window sum and neighbor
// maximum, so hits of a cluster stream at one per cycle while full is low.
// The last hit of a cluster places a job in a two-entry queue; the back end
// then registers the result directly for an empty window, or else forms the
// quotient one bit per step over the 40-bit scaled numerator and saturates
// it before the result appears, and it holds that result until it is popped.
// full rises only while the job queue holds two clusters, so the front
// stalls only when short clusters arrive faster than the back end finishes
// them, or while a result waits unpopped and the queue behind it fills.
// Reset is synchronous and active low; it restores the register defaults and
// starts a fresh cluster. The config port is always ready for every write.
// ----------------------------------------------------------------------------
module crystal_cluster_e2e9_spike (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,

    input  logic                                      push,
    output logic                                      full,
    input  logic signed [ccs_pkg::ETA_BITS-1:0]       i_eta_index,
    input  logic [ccs_pkg::PHI_BITS-1:0]              i_phi_index,
    input  logic signed [ccs_pkg::ENERGY_BITS-1:0]    i_energy,
    input  logic                                      i_last_hit,

    output logic                                      empty,
    input  logic                                      pop,
    output logic signed [ccs_pkg::RATIO_BITS-1:0]     o_ratio,
    output logic                                      o_is_spike,
    output logic                                      o_no_energy,

    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [ccs_pkg::CFG_INDEX_BITS-1:0]        i_cfg_index,
    input  logic [ccs_pkg::CFG_DATA_BITS-1:0]         i_cfg_data
);

    ccs_pkg::t_cfg    r_cfg;
    ccs_pkg::t_job    front_job;
    ccs_pkg::t_job    queue_job;
    ccs_pkg::t_result result;
    logic             hit_accept;
    logic             job_push;
    logic             job_pop;
    logic             job_valid;
    logic             queue_full;

    // The config port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_hits         <= ccs_pkg::MAX_HITS_RST;
            r_cfg.spike_threshold  <= ccs_pkg::THRESH_RST;
            r_cfg.neighbor_floor   <= ccs_pkg::FLOOR_RST;
            r_cfg.barrel_eta_limit <= ccs_pkg::LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (ccs_pkg::t_cfg_index'(i_cfg_index))
                ccs_pkg::CFG_MAX_HITS:
                    r_cfg.max_hits <= i_cfg_data[ccs_pkg::MAX_HITS_BITS-1:0];
                ccs_pkg::CFG_SPIKE_THR:
                    r_cfg.spike_threshold <= i_cfg_data[ccs_pkg::THRESH_BITS-1:0];
                ccs_pkg::CFG_NBR_FLOOR:
                    r_cfg.neighbor_floor <= $signed(i_cfg_data[ccs_pkg::FLOOR_BITS-1:0]);
                ccs_pkg::CFG_ETA_LIMIT:
                    r_cfg.barrel_eta_limit <= i_cfg_data[ccs_pkg::LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // A hit beat is refused only while the job queue is full, so the last
    // hit of a cluster always finds room for its job.
    assign full       = queue_full;
    assign hit_accept = push && !queue_full;

    ccs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (hit_accept),
        .i_eta_index (i_eta_index),
        .i_phi_index (i_phi_index),
        .i_energy    (i_energy),
        .i_last_hit  (i_last_hit),
        .o_job_push  (job_push),
        .o_job       (front_job)
    );

    ccs_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .i_pop   (job_pop),
        .o_job   (queue_job),
        .o_valid (job_valid),
        .o_full  (queue_full)
    );

    ccs_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_cfg.spike_threshold),
        .i_job_valid (job_valid),
        .i_job       (queue_job),
        .o_job_pop   (job_pop),
        .i_pop       (pop && !empty),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign o_ratio     = result.ratio;
    assign o_is_spike  = result.is_spike;
    assign o_no_energy = result.no_energy;

    a_spike_needs_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_is_spike) |-> (!o_no_energy && !o_ratio[ccs_pkg::RATIO_BITS-1]))
        else $error("spike flagged without a positive ratio");

endmodule

// ----- sv/ccs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_front: per-hit accumulation
// Latches the seed, tests each hit against the 3x3 window around it, the eta
// limit and max_hits, keeps the window sum and the neighbor maximum, and
// hands a job to the queue on the last hit of a cluster.
// ----------------------------------------------------------------------------
module ccs_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ccs_pkg::t_cfg                          i_cfg,
    input  logic                                   i_accept,
    input  logic signed [ccs_pkg::ETA_BITS-1:0]    i_eta_index,
    input  logic [ccs_pkg::PHI_BITS-1:0]           i_phi_index,
    input  logic signed [ccs_pkg::ENERGY_BITS-1:0] i_energy,
    input  logic                                   i_last_hit,
    output logic                                   o_job_push,
    output ccs_pkg::t_job                          o_job
);

    logic signed [ccs_pkg::ETA_BITS-1:0]    r_seed_eta,    n_seed_eta;
    logic [ccs_pkg::PHI_BITS-1:0]           r_seed_phi,    n_seed_phi;
    logic signed [ccs_pkg::ENERGY_BITS-1:0] r_seed_energy, n_seed_energy;
    logic signed [ccs_pkg::SUM_BITS-1:0]    r_sum,         n_sum;
    logic signed [ccs_pkg::NMAX_BITS-1:0]   r_nmax,        n_nmax;
    logic [ccs_pkg::HIT_INDEX_BITS-1:0]     r_pos,         n_pos;

    logic                                   is_seed;
    logic                                   in_window;
    logic                                   use_hit;
    logic [ccs_pkg::ETA_BITS-1:0]           abs_eta;
    logic signed [ccs_pkg::ETA_BITS:0]      sh_seed;
    logic signed [ccs_pkg::ETA_BITS:0]      sh_hit;
    logic signed [ccs_pkg::ETA_BITS:0]      d_eta;
    logic signed [ccs_pkg::PHI_BITS:0]      d_phi;
    logic signed [ccs_pkg::SUM_BITS-1:0]    sum_base;
    logic signed [ccs_pkg::NMAX_BITS-1:0]   nmax_base;
    logic signed [ccs_pkg::NMAX_BITS-1:0]   energy_ext;
    logic [ccs_pkg::POS_CMP_BITS-1:0]       pos_ext;
    logic [ccs_pkg::POS_CMP_BITS-1:0]       max_ext;

    always_comb begin
        is_seed       = (r_pos == '0);
        n_seed_eta    = is_seed ? i_eta_index : r_seed_eta;
        n_seed_phi    = is_seed ? i_phi_index : r_seed_phi;
        n_seed_energy = is_seed ? i_energy    : r_seed_energy;
        sum_base      = is_seed ? '0 : r_sum;
        nmax_base     = is_seed ? ccs_pkg::NMAX_BITS'(i_cfg.neighbor_floor) : r_nmax;

        abs_eta = i_eta_index[ccs_pkg::ETA_BITS-1] ? ccs_pkg::ETA_BITS'(-i_eta_index)
                                                   : ccs_pkg::ETA_BITS'(i_eta_index);
        pos_ext = ccs_pkg::POS_CMP_BITS'(r_pos);
        max_ext = ccs_pkg::POS_CMP_BITS'(i_cfg.max_hits);

        // Negative eta indices move up by one so that the barrel has no gap.
        sh_seed = (ccs_pkg::ETA_BITS+1)'(n_seed_eta)
                + $signed({{ccs_pkg::ETA_BITS{1'b0}}, n_seed_eta[ccs_pkg::ETA_BITS-1]});
        sh_hit  = (ccs_pkg::ETA_BITS+1)'(i_eta_index)
                + $signed({{ccs_pkg::ETA_BITS{1'b0}}, i_eta_index[ccs_pkg::ETA_BITS-1]});
        d_eta   = sh_seed - sh_hit;
        d_phi   = $signed({1'b0, n_seed_phi}) - $signed({1'b0, i_phi_index});

        // A phi step across the 360/1 boundary counts as a single step.
        in_window = ((d_eta >= -1) && (d_eta <= 1))
                 && ((d_phi >= -1) && (d_phi <= 1)
                     || (d_phi == (ccs_pkg::PHI_BITS+1)'(ccs_pkg::PHI_WRAP))
                     || (d_phi == -(ccs_pkg::PHI_BITS+1)'(ccs_pkg::PHI_WRAP)));

        use_hit = (pos_ext < max_ext)
               && (abs_eta <= {1'b0, i_cfg.barrel_eta_limit})
               && in_window;

        energy_ext = ccs_pkg::NMAX_BITS'(i_energy);
        n_sum      = use_hit ? sum_base + ccs_pkg::SUM_BITS'(i_energy) : sum_base;
        n_nmax     = (use_hit && !is_seed && (energy_ext > nmax_base)) ? energy_ext
                                                                       : nmax_base;

        if (i_last_hit) begin
            n_pos = '0;
        end else if (r_pos != '1) begin
            n_pos = r_pos + 1'b1;
        end else begin
            n_pos = r_pos;
        end

        o_job_push = i_accept && i_last_hit;
        o_job.num  = ccs_pkg::NUM_BITS'(n_nmax) + ccs_pkg::NUM_BITS'(n_seed_energy);
        o_job.sum  = n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_eta    <= '0;
            r_seed_phi    <= '0;
            r_seed_energy <= '0;
            r_sum         <= '0;
            r_nmax        <= ccs_pkg::NMAX_BITS'(ccs_pkg::FLOOR_RST);
            r_pos         <= '0;
        end else if (i_accept) begin
            r_seed_eta    <= n_seed_eta;
            r_seed_phi    <= n_seed_phi;
            r_seed_energy <= n_seed_energy;
            r_sum         <= n_sum;
            r_nmax        <= n_nmax;
            r_pos         <= n_pos;
        end
    end

    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_hit) |=> (r_pos == '0))
        else $error("hit position did not restart after the last hit");

endmodule

// ----- sv/ccs_job_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_job_fifo: two-entry queue of finished clusters
// Decouples hit accumulation from the division so each side stalls alone.
// ----------------------------------------------------------------------------
module ccs_job_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ccs_pkg::t_job i_job,
    input  logic          i_pop,
    output ccs_pkg::t_job o_job,
    output logic          o_valid,
    output logic          o_full
);

    ccs_pkg::t_job r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_job   = r_mem[r_rd_ptr];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("job queue read while empty");

endmodule

// ----- sv/ccs_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_divider: ratio back end
// Takes one job at a time, marks a window sum of zero or less as empty, or
// divides the Q15-scaled numerator magnitude by the sum one quotient bit per
// cycle, saturates, applies the sign and the spike threshold, and holds it until popped.
// ----------------------------------------------------------------------------
module ccs_divider (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [ccs_pkg::THRESH_BITS-1:0]   i_threshold,
    input  logic                              i_job_valid,
    input  ccs_pkg::t_job                     i_job,
    output logic                              o_job_pop,
    input  logic                              i_pop,
    output logic                              o_empty,
    output ccs_pkg::t_result                  o_result
);

    localparam logic [ccs_pkg::DVD_BITS-1:0] POS_LIM =
        ccs_pkg::DVD_BITS'(2**(ccs_pkg::RATIO_BITS-1) - 1);
    localparam logic [ccs_pkg::DVD_BITS-1:0] NEG_LIM =
        ccs_pkg::DVD_BITS'(2**(ccs_pkg::RATIO_BITS-1));

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    t_state                           r_state;
    logic [ccs_pkg::DVS_BITS-1:0]     r_rem;
    logic [ccs_pkg::DVS_BITS-1:0]     r_div;
    logic [ccs_pkg::DVD_BITS-1:0]     r_quot;
    logic [ccs_pkg::CNT_BITS-1:0]     r_cnt;
    logic                             r_neg;
    ccs_pkg::t_result                 r_result;

    logic [ccs_pkg::DVS_BITS:0]       trial;
    logic                             fits;
    logic [ccs_pkg::NUM_BITS-1:0]     num_mag;
    logic [ccs_pkg::DVD_BITS-1:0]     q_sat;
    logic signed [ccs_pkg::RATIO_BITS-1:0] ratio_fin;

    always_comb begin
        trial   = {r_rem, r_quot[ccs_pkg::DVD_BITS-1]};
        fits    = (trial >= {1'b0, r_div});
        num_mag = i_job.num[ccs_pkg::NUM_BITS-1] ? ccs_pkg::NUM_BITS'(-i_job.num)
                                                 : ccs_pkg::NUM_BITS'(i_job.num);
        if (r_neg) begin
            q_sat = (r_quot > NEG_LIM) ? NEG_LIM : r_quot;
            ratio_fin = -$signed(q_sat[ccs_pkg::RATIO_BITS-1:0]);
        end else begin
            q_sat = (r_quot > POS_LIM) ? POS_LIM : r_quot;
            ratio_fin = $signed(q_sat[ccs_pkg::RATIO_BITS-1:0]);
        end
        o_job_pop = (r_state == S_IDLE) && i_job_valid;
        o_empty   = (r_state != S_OUT);
        o_result  = r_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_result <= '0;
            r_rem    <= '0;
            r_div    <= '0;
            r_quot   <= '0;
            r_cnt    <= '0;
            r_neg    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        if (i_job.sum <= 0) begin
                            r_result.ratio     <= '0;
                            r_result.is_spike  <= 1'b0;
                            r_result.no_energy <= 1'b1;
                            r_state            <= S_OUT;
                        end else begin
                            r_rem   <= '0;
                            r_div   <= i_job.sum[ccs_pkg::DVS_BITS-1:0];
                            r_quot  <= {num_mag, {ccs_pkg::FRAC_BITS{1'b0}}};
                            r_neg   <= i_job.num[ccs_pkg::NUM_BITS-1];
                            r_cnt   <= ccs_pkg::CNT_BITS'(ccs_pkg::DVD_BITS);
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= fits ? ccs_pkg::DVS_BITS'(trial - {1'b0, r_div})
                                   : ccs_pkg::DVS_BITS'(trial);
                    r_quot <= {r_quot[ccs_pkg::DVD_BITS-2:0], fits};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == ccs_pkg::CNT_BITS'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_result.ratio     <= ratio_fin;
                    r_result.is_spike  <= !r_neg
                        && (q_sat > ccs_pkg::DVD_BITS'(i_threshold));
                    r_result.no_energy <= 1'b0;
                    r_state            <= S_OUT;
                end
                S_OUT: begin
                    if (i_pop) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div))
        else $error("partial remainder not below the divisor");

    a_no_energy_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_result.no_energy) |->
            (r_result.ratio == '0 && !r_result.is_spike))
        else $error("empty window produced a nonzero ratio or spike");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the crystal cluster E2/E9 spike filter
// Streams clusters of crystal hits through the queue-style hit port, keeps a
// cycle-free model of the window sum, neighbor maximum and Q15 ratio, and
// compares every popped result beat field by field with the oldest predicted
// one. Register settings change between cluster groups while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

    // Run shape. The stall limit sits well above the longest quiet stretch a
    // correct run can show: the receiver hold plus a full division and the
    // settling pause between phases.
    localparam int IDLE_PCT      = 34;
    localparam int RANDOM_HITS   = 360;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 48;
    localparam int STALL_LIMIT   = 3000;
    localparam int PRINT_LIMIT   = 30;

    localparam logic signed [ccs_pkg::ENERGY_BITS-1:0] ENERGY_TOP =
        {1'b0, {(ccs_pkg::ENERGY_BITS-1){1'b1}}};
    localparam logic signed [ccs_pkg::ENERGY_BITS-1:0] ENERGY_BOTTOM =
        {1'b1, {(ccs_pkg::ENERGY_BITS-1){1'b0}}};
    localparam longint Q15_ONE   = 64'sd32768;
    localparam longint RATIO_TOP = (64'sd1 <<< (ccs_pkg::RATIO_BITS - 1)) - 1;
    localparam longint RATIO_BOT = -(64'sd1 <<< (ccs_pkg::RATIO_BITS - 1));

    // One hit beat as it travels on the input ports.
    typedef struct packed {
        logic signed [ccs_pkg::ETA_BITS-1:0]    eta;
        logic [ccs_pkg::PHI_BITS-1:0]           phi;
        logic signed [ccs_pkg::ENERGY_BITS-1:0] energy;
        logic                                   last;
    } t_crystal_hit;

    // Every input starts at a known value; reset is held low from time zero.
    logic                                   i_clk       = 1'b0;
    logic                                   i_rst_n     = 1'b0;
    logic                                   push        = 1'b0;
    logic                                   full;
    logic signed [ccs_pkg::ETA_BITS-1:0]    i_eta_index = '0;
    logic [ccs_pkg::PHI_BITS-1:0]           i_phi_index = '0;
    logic signed [ccs_pkg::ENERGY_BITS-1:0] i_energy    = '0;
    logic                                   i_last_hit  = 1'b0;
    logic                                   empty;
    logic                                   pop         = 1'b0;
    logic signed [ccs_pkg::RATIO_BITS-1:0]  o_ratio;
    logic                                   o_is_spike;
    logic                                   o_no_energy;
    logic                                   i_cfg_valid = 1'b0;
    logic                                   o_cfg_ready;
    logic [ccs_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index = '0;
    logic [ccs_pkg::CFG_DATA_BITS-1:0]      i_cfg_data  = '0;

    crystal_cluster_e2e9_spike DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_eta_index (i_eta_index),
        .i_phi_index (i_phi_index),
        .i_energy    (i_energy),
        .i_last_hit  (i_last_hit),
        .empty       (empty),
        .pop         (pop),
        .o_ratio     (o_ratio),
        .o_is_spike  (o_is_spike),
        .o_no_energy (o_no_energy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model state: the register copy and the per-cluster accumulation.
    // ------------------------------------------------------------------
    ccs_pkg::t_cfg                           cfg_model;
    logic signed [ccs_pkg::ETA_BITS-1:0]     seed_eta;
    logic [ccs_pkg::PHI_BITS-1:0]            seed_phi;
    logic signed [ccs_pkg::ENERGY_BITS-1:0]  seed_energy;
    logic signed [ccs_pkg::SUM_BITS-1:0]     window_sum;
    logic signed [ccs_pkg::NMAX_BITS-1:0]    neighbor_max;
    logic [ccs_pkg::HIT_INDEX_BITS-1:0]      hit_pos;

    // Predicted result beats, oldest first.
    ccs_pkg::t_result pending_ratios[$];

    // Traffic control shared by the stimulus and the result side.
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    int recv_hold    = 0;

    // Bookkeeping for the verdict and the closing summary.
    int mismatches     = 0;
    int hits_sent      = 0;
    int clusters_done  = 0;
    int spikes_seen    = 0;
    int empty_windows  = 0;
    int saturated      = 0;
    int stalled_beats  = 0;
    int setting_writes = 0;

    // Negative eta indices move up by one so that the barrel has no hole at
    // zero and eta -1 sits next to eta +1.
    function automatic int close_gap(input int eta);
        return (eta < 0) ? eta + 1 : eta;
    endfunction

    // Folds one accepted hit into the model. On the last hit of a cluster it
    // works out the ratio beat that the block must deliver and queues it.
    function automatic void fold_crystal_hit(input t_crystal_hit h);
        int               eta_abs;
        int               d_eta;
        int               d_phi;
        longint           numer;
        longint           quot;
        ccs_pkg::t_result beat;

        eta_abs = ($signed(h.eta) < 0) ? -int'($signed(h.eta)) : int'($signed(h.eta));

        // The first hit of a cluster is always taken as the seed, even when
        // the eta limit or max_hits later keeps it out of the window sum.
        if (hit_pos == '0) begin
            seed_eta     = h.eta;
            seed_phi     = h.phi;
            seed_energy  = h.energy;
            window_sum   = '0;
            neighbor_max = cfg_model.neighbor_floor;
        end

        if (hit_pos < cfg_model.max_hits && eta_abs <= int'(cfg_model.barrel_eta_limit)) begin
            d_eta = close_gap(int'($signed(seed_eta))) - close_gap(int'($signed(h.eta)));
            d_phi = int'(seed_phi) - int'(h.phi);
            // Phi wraps around the barrel only at an exact 359 step.
            if (d_phi == -ccs_pkg::PHI_WRAP)
                d_phi = 1;
            else if (d_phi == ccs_pkg::PHI_WRAP)
                d_phi = -1;
            if (d_phi >= -1 && d_phi <= 1 && d_eta >= -1 && d_eta <= 1) begin
                window_sum = window_sum + $signed(h.energy);
                if (hit_pos != '0 && $signed(h.energy) > neighbor_max)
                    neighbor_max = h.energy;
            end
        end

        // The position counter sticks at all ones on very long clusters.
        if (hit_pos != '1)
            hit_pos = hit_pos + 1'b1;

        if (h.last) begin
            beat = '0;
            if (window_sum <= 0) begin
                beat.no_energy = 1'b1;
            end else begin
                numer = (longint'(neighbor_max) + longint'(seed_energy)) * Q15_ONE;
                quot  = numer / longint'(window_sum);
                if (quot > RATIO_TOP)
                    quot = RATIO_TOP;
                if (quot < RATIO_BOT)
                    quot = RATIO_BOT;
                beat.ratio    = quot[ccs_pkg::RATIO_BITS-1:0];
                beat.is_spike = (quot > longint'(cfg_model.spike_threshold));
            end
            pending_ratios = {pending_ratios, beat};
            hit_pos = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Hit side helpers.
    // ------------------------------------------------------------------
    function automatic t_crystal_hit mk_hit(input int eta, input int phi,
                                            input int energy, input bit last);
        t_crystal_hit h;
        h.eta    = eta[ccs_pkg::ETA_BITS-1:0];
        h.phi    = phi[ccs_pkg::PHI_BITS-1:0];
        h.energy = energy[ccs_pkg::ENERGY_BITS-1:0];
        h.last   = last;
        return h;
    endfunction

    function automatic logic signed [ccs_pkg::ENERGY_BITS-1:0] pick_energy();
        case ($urandom_range(9))
            0:       return ccs_pkg::ENERGY_BITS'($urandom);
            1:       return $urandom_range(1) ? ENERGY_TOP : ENERGY_BOTTOM;
            2:       return -ccs_pkg::ENERGY_BITS'($urandom_range(3000));
            default: return ccs_pkg::ENERGY_BITS'($urandom_range(30000));
        endcase
    endfunction

    // A seed mostly inside the barrel, often on the phi seam so that the
    // wrap of the neighbors gets exercised.
    function automatic t_crystal_hit make_seed();
        t_crystal_hit h;
        int lim;
        int e;
        int p;
        lim = int'(cfg_model.barrel_eta_limit);
        if ($urandom_range(99) < 80 && lim > 0) begin
            e = $urandom_range(1, lim);
            if ($urandom_range(1))
                e = -e;
        end else begin
            e = int'($urandom_range(255)) - 128;
        end
        case ($urandom_range(9))
            0, 1:    p = 1;
            2:       p = 360;
            9:       p = $urandom_range(511);
            default: p = $urandom_range(1, 360);
        endcase
        return mk_hit(e, p, int'(pick_energy()), 1'b0);
    endfunction

    // A hit at most one step from the seed in both directions, stepping over
    // the eta gap and around the phi seam the way the detector does.
    function automatic t_crystal_hit near_hit(input t_crystal_hit seed_hit);
        int s;
        int e;
        int p;
        s = close_gap(int'($signed(seed_hit.eta))) + int'($urandom_range(2)) - 1;
        e = (s <= 0) ? s - 1 : s;
        if (e < -128 || e > 127)
            e = int'($signed(seed_hit.eta));
        p = int'(seed_hit.phi) + int'($urandom_range(2)) - 1;
        if (seed_hit.phi >= 1 && seed_hit.phi <= 360) begin
            if (p == 0)
                p = 360;
            else if (p == 361)
                p = 1;
        end else if (p < 0 || p > 511) begin
            p = int'(seed_hit.phi);
        end
        return mk_hit(e, p, int'(pick_energy()), 1'b0);
    endfunction

    // Offers one hit beat and returns at the edge where it was taken. The
    // push line stays high into the next beat unless the sender idles.
    task automatic send_hit(input t_crystal_hit h);
        while (send_idle_on && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_eta_index <= h.eta;
        i_phi_index <= h.phi;
        i_energy    <= h.energy;
        i_last_hit  <= h.last;
        @(posedge i_clk);
        while (full) begin
            stalled_beats++;
            @(posedge i_clk);
        end
        fold_crystal_hit(h);
        hits_sent++;
    endtask

    task automatic send_cluster(input int n_hits, input int noise_pct);
        t_crystal_hit seed_hit;
        t_crystal_hit h;
        seed_hit      = make_seed();
        seed_hit.last = (n_hits == 1);
        send_hit(seed_hit);
        for (int k = 1; k < n_hits; k++) begin
            if ($urandom_range(99) < noise_pct)
                h = t_crystal_hit'({$urandom, $urandom});
            else
                h = near_hit(seed_hit);
            h.last = (k == n_hits - 1);
            send_hit(h);
        end
    endtask

    // Stops offering hits, waits until every predicted beat has been popped,
    // then lets the divider settle before anything else happens.
    task automatic wait_drain();
        push <= 1'b0;
        while (pending_ratios.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Register side. All four registers are written back to back with the
    // valid line held high across the beats.
    // ------------------------------------------------------------------
    function automatic ccs_pkg::t_cfg make_cfg(input int mh, input int thr, input int fl,
                                               input int lim);
        ccs_pkg::t_cfg c;
        c.max_hits         = mh[ccs_pkg::MAX_HITS_BITS-1:0];
        c.spike_threshold  = thr[ccs_pkg::THRESH_BITS-1:0];
        c.neighbor_floor   = fl[ccs_pkg::FLOOR_BITS-1:0];
        c.barrel_eta_limit = lim[ccs_pkg::LIMIT_BITS-1:0];
        return c;
    endfunction

    function automatic ccs_pkg::t_cfg random_cfg();
        int mh;
        int thr;
        int fl;
        int lim;
        case ($urandom_range(5))
            0:       mh = 0;
            1:       mh = 1;
            2:       mh = 3;
            3:       mh = 1023;
            default: mh = $urandom_range(2, 120);
        endcase
        case ($urandom_range(4))
            0:       thr = 0;
            1:       thr = 65535;
            2:       thr = 31130;
            default: thr = $urandom_range(65535);
        endcase
        case ($urandom_range(4))
            0:       fl = -8388608;
            1:       fl = 8388607;
            2:       fl = -10000;
            default: fl = int'($signed(ccs_pkg::FLOOR_BITS'($urandom)));
        endcase
        case ($urandom_range(4))
            0:       lim = 0;
            1:       lim = 127;
            2:       lim = 85;
            default: lim = $urandom_range(127);
        endcase
        return make_cfg(mh, thr, fl, lim);
    endfunction

    task automatic write_registers(input ccs_pkg::t_cfg c);
        ccs_pkg::t_cfg_index               reg_order[4];
        logic [ccs_pkg::CFG_DATA_BITS-1:0] value;
        reg_order = '{ccs_pkg::CFG_MAX_HITS, ccs_pkg::CFG_SPIKE_THR,
                      ccs_pkg::CFG_NBR_FLOOR, ccs_pkg::CFG_ETA_LIMIT};
        foreach (reg_order[k]) begin
            case (reg_order[k])
                ccs_pkg::CFG_MAX_HITS:
                    value = ccs_pkg::CFG_DATA_BITS'(c.max_hits);
                ccs_pkg::CFG_SPIKE_THR:
                    value = ccs_pkg::CFG_DATA_BITS'(c.spike_threshold);
                ccs_pkg::CFG_NBR_FLOOR:
                    value = ccs_pkg::CFG_DATA_BITS'(c.neighbor_floor);
                default:
                    value = ccs_pkg::CFG_DATA_BITS'(c.barrel_eta_limit);
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_order[k];
            i_cfg_data  <= value;
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            case (reg_order[k])
                ccs_pkg::CFG_MAX_HITS:
                    cfg_model.max_hits = value[ccs_pkg::MAX_HITS_BITS-1:0];
                ccs_pkg::CFG_SPIKE_THR:
                    cfg_model.spike_threshold = value[ccs_pkg::THRESH_BITS-1:0];
                ccs_pkg::CFG_NBR_FLOOR:
                    cfg_model.neighbor_floor = value[ccs_pkg::FLOOR_BITS-1:0];
                default:
                    cfg_model.barrel_eta_limit = value[ccs_pkg::LIMIT_BITS-1:0];
            endcase
        end
        i_cfg_valid <= 1'b0;
        setting_writes++;
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Hand-built clusters under the reset register values: a clean spike,
    // the eta gap, the phi seam in both directions, saturation at both ends
    // of the ratio, empty and negative windows, and the field extremes.
    task automatic test_directed_clusters();
        // Seed plus one neighbor, with no other hits, gives exactly one in Q15.
        send_hit(mk_hit(5, 100, 10000, 1'b0));
        send_hit(mk_hit(6, 100, 9000, 1'b1));
        // Eta -1 neighbors eta +1; phi 1 neighbors phi 360. Two hits fall
        // just outside the window, one in eta and one in phi.
        send_hit(mk_hit(1, 360, 20000, 1'b0));
        send_hit(mk_hit(-1, 1, 3000, 1'b0));
        send_hit(mk_hit(-2, 359, 500, 1'b0));
        send_hit(mk_hit(2, 359, 100, 1'b0));
        send_hit(mk_hit(1, 2, 700, 1'b1));
        // The seam seen from the other side.
        send_hit(mk_hit(-3, 1, 5000, 1'b0));
        send_hit(mk_hit(-4, 360, 4000, 1'b1));
        // A window sum of one drives the ratio into its upper clamp.
        send_hit(mk_hit(10, 50, 8388607, 1'b0));
        send_hit(mk_hit(10, 51, -8388606, 1'b1));
        // The seed lies outside the barrel but still feeds the numerator,
        // which pushes the ratio into its lower clamp.
        send_hit(mk_hit(86, 20, -8388608, 1'b0));
        send_hit(mk_hit(85, 20, 1, 1'b1));
        // Negative window, window emptied by the eta limit, and a cluster
        // made only of the field extremes.
        send_hit(mk_hit(0, 0, -5, 1'b1));
        send_hit(mk_hit(-128, 511, 8388607, 1'b1));
        send_hit(mk_hit(127, 511, -8388608, 1'b0));
        send_hit(mk_hit(-128, 0, 8388607, 1'b1));
        // A neighbor one past the eta limit is dropped.
        send_hit(mk_hit(-85, 200, 3000, 1'b0));
        send_hit(mk_hit(-86, 200, 9999, 1'b0));
        send_hit(mk_hit(-84, 201, 2000, 1'b1));
        // Energies that cancel leave a zero window.
        send_hit(mk_hit(40, 180, 100, 1'b0));
        send_hit(mk_hit(40, 181, -100, 1'b1));
        wait_drain();
    endtask

    // Walks the registers through their extremes. Each setting gets a few
    // short clusters plus one that is longer than a small max_hits.
    task automatic test_register_extremes();
        ccs_pkg::t_cfg plan[6];
        plan[0] = make_cfg(0, 0, 0, 127);
        plan[1] = make_cfg(1, 0, -8388608, 0);
        plan[2] = make_cfg(3, 65535, 8388607, 127);
        plan[3] = make_cfg(5, 16384, -8388608, 1);
        plan[4] = make_cfg(1023, 31130, -10000, 85);
        plan[5] = make_cfg(100, 31130, -10000, 85);
        foreach (plan[k]) begin
            write_registers(plan[k]);
            repeat (4) send_cluster($urandom_range(1, 8), 20);
            send_cluster(7, 0);
            wait_drain();
        end
    endtask

    // The receiver stops popping for a long stretch while the sender keeps
    // offering one-hit clusters that each need a full division. The output
    // register and the job queue fill, so full must hold the hit port. The
    // sender then stops until every result has come out.
    task automatic test_backpressure();
        send_idle_on = 1'b0;
        recv_hold    = HOLD_CYCLES;
        repeat (16)
            send_hit(mk_hit(3, 10, 1000 + $urandom_range(5000), 1'b1));
        wait_drain();
        send_idle_on = 1'b1;
    endtask

    // Mostly well-formed clusters with random content and lengths, with
    // random hits mixed in, and fresh register settings every 15 clusters.
    // The first stretch runs with neither side idling.
    task automatic test_random_clusters();
        int start_hits;
        int since_cfg;
        int len;
        start_hits   = hits_sent;
        since_cfg    = 0;
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        while (hits_sent - start_hits < RANDOM_HITS) begin
            if (hits_sent - start_hits >= 120) begin
                send_idle_on = 1'b1;
                recv_idle_on = 1'b1;
            end
            if (since_cfg == 15) begin
                wait_drain();
                write_registers(random_cfg());
                since_cfg = 0;
            end
            case ($urandom_range(19))
                0:          len = $urandom_range(20, 40);
                1, 2, 3, 4: len = 1;
                default:    len = $urandom_range(2, 9);
            endcase
            send_cluster(len, 15);
            since_cfg++;
        end
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Result side: checks each popped beat against the oldest prediction
    // and chooses whether to pop on the next edge. A hold request from a
    // test is counted down here at each edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        ccs_pkg::t_result want;
        if (pop && !empty) begin
            if (pending_ratios.size() == 0) begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t result beat with nothing predicted: ratio %0d", $time,
                             o_ratio);
            end else begin
                want = pending_ratios.pop_front();
                clusters_done++;
                if (want.is_spike)
                    spikes_seen++;
                if (want.no_energy)
                    empty_windows++;
                if (!want.no_energy &&
                    ($signed(want.ratio) == RATIO_TOP || $signed(want.ratio) == RATIO_BOT))
                    saturated++;
                if (o_ratio !== want.ratio) begin
                    mismatches++;
                    if (mismatches <= PRINT_LIMIT)
                        $display("%0t ratio: expected %0d, got %0d", $time,
                                 $signed(want.ratio), o_ratio);
                end
                if (o_is_spike !== want.is_spike) begin
                    mismatches++;
                    if (mismatches <= PRINT_LIMIT)
                        $display("%0t is_spike: expected %0b, got %0b", $time,
                                 want.is_spike, o_is_spike);
                end
                if (o_no_energy !== want.no_energy) begin
                    mismatches++;
                    if (mismatches <= PRINT_LIMIT)
                        $display("%0t no_energy: expected %0b, got %0b", $time,
                                 want.no_energy, o_no_energy);
                end
            end
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (recv_hold > 0) begin
            pop <= 1'b0;
            recv_hold = recv_hold - 1;
        end else begin
            pop <= !recv_idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: any beat on any channel clears the count of quiet cycles.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t no beat moved for %0d cycles, %0d results outstanding", $time,
                     quiet_cycles, pending_ratios.size());
            $display("crystal_cluster_e2e9_spike verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------
    initial begin
        cfg_model.max_hits         = ccs_pkg::MAX_HITS_RST;
        cfg_model.spike_threshold  = ccs_pkg::THRESH_RST;
        cfg_model.neighbor_floor   = ccs_pkg::FLOOR_RST;
        cfg_model.barrel_eta_limit = ccs_pkg::LIMIT_RST;
        seed_eta     = '0;
        seed_phi     = '0;
        seed_energy  = '0;
        window_sum   = '0;
        neighbor_max = ccs_pkg::FLOOR_RST;
        hit_pos      = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_clusters();
        test_register_extremes();
        test_backpressure();
        test_random_clusters();

        $display("Covered %0d hits in %0d clusters over %0d register settings.",
                 hits_sent, clusters_done, setting_writes);
        $display("Spikes %0d, empty windows %0d, clamped ratios %0d, stalled hit cycles %0d.",
                 spikes_seen, empty_windows, saturated, stalled_beats);
        if (mismatches == 0)
            $display("crystal_cluster_e2e9_spike verification clean");
        else
            $display("crystal_cluster_e2e9_spike verification failed");
        $finish;
    end

endmodule

// ----- crystal_cluster_e2e9_spike.f -----
sv/ccs_pkg.sv
sv/ccs_front.sv
sv/ccs_job_fifo.sv
sv/ccs_divider.sv
sv/crystal_cluster_e2e9_spike.sv
tb/testbench.sv
